// ----- design/pfpt_pkg.sv -----
// ----------------------------------------------------------------------------
// pfpt_pkg
// Shared widths, action codes and the command type of the port filter table.
// ----------------------------------------------------------------------------
package pfpt_pkg;

	localparam int PORT_W   = 16;
	localparam int PROTO_W  = 8;
	localparam int ACTION_W = 2;
	localparam int KEY_W    = PROTO_W + PORT_W;
	localparam int SUM_W    = PORT_W + 1;

	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [KEY_W-1:0]    key;
	} cmd_t;

	typedef struct packed {
		logic          valid;
		logic [KEY_W-1:0] key;
	} slot_t;

endpackage

// ----- design/pfpt_req_if.sv -----
// ----------------------------------------------------------------------------
// pfpt_req_if
// Request channel: action, port and protocol with valid/ready.
// ----------------------------------------------------------------------------
interface pfpt_req_if
	import pfpt_pkg::*;
	();

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [PORT_W-1:0]   port;
	logic [PROTO_W-1:0]  protocol;

	modport source (output valid, output action, output port, output protocol, input ready);
	modport sink   (input valid, input action, input port, input protocol, output ready);

endinterface

// ----- design/pfpt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfpt_rsp_if
// Response channel: matched and status with valid/ready.
// ----------------------------------------------------------------------------
interface pfpt_rsp_if;

	logic valid;
	logic ready;
	logic matched;
	logic status;

	modport source (output valid, output matched, output status, input ready);
	modport sink   (input valid, input matched, input status, output ready);

endinterface

// ----- design/pfpt_ram.sv -----
// ----------------------------------------------------------------------------
// pfpt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/pfpt_queue.sv -----
// ----------------------------------------------------------------------------
// pfpt_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pfpt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] buf_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = buf_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= push_data;
		end
	end

endmodule

// ----- design/pfpt_front.sv -----
// ----------------------------------------------------------------------------
// pfpt_front
// Accepts requests, forms the key and reduces port + protocol modulo the
// table size by reciprocal multiplication in a multiply and a subtract step.
// ----------------------------------------------------------------------------
module pfpt_front
	import pfpt_pkg::*;
#(
	parameter int ENTRIES = 64,
	localparam int IDX_W  = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	pfpt_req_if.sink         req,
	input  logic             hold,
	output logic             push_valid,
	input  logic             push_ready,
	output cmd_t             push_cmd,
	output logic [IDX_W-1:0] push_start
);

	localparam int     SHIFT = SUM_W + $clog2(ENTRIES);
	localparam int     RCP_W = SUM_W + 1;
	localparam int     PRD_W = SUM_W + RCP_W;
	localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(ENTRIES) - 1)
		/ longint'(ENTRIES);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_SUB  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t          state_q;
	cmd_t             cmd_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] quo_q;
	logic [IDX_W-1:0] start_q;
	logic [SUM_W-1:0] sum;
	logic [PRD_W-1:0] prod;
	logic             take;

	assign req.ready  = (state_q == F_IDLE) && !hold;
	assign take       = req.valid && req.ready;
	assign sum        = SUM_W'(req.port) + SUM_W'(req.protocol);
	assign prod       = PRD_W'(sum_q) * PRD_W'(RECIP);
	assign push_valid = (state_q == F_PUSH);
	assign push_cmd   = cmd_q;
	assign push_start = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_SUB;
				end
				F_SUB: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q.action <= req.action;
			cmd_q.key    <= {req.protocol, req.port};
			sum_q        <= sum;
		end
		if (state_q == F_MUL) begin
			quo_q <= SUM_W'(prod >> SHIFT);
		end
		// remainder is below ENTRIES, so only its low bits are formed
		if (state_q == F_SUB) begin
			start_q <= sum_q[IDX_W-1:0] - IDX_W'(quo_q * SUM_W'(ENTRIES));
		end
	end

endmodule

// ----- design/pfpt_back.sv -----
// ----------------------------------------------------------------------------
// pfpt_back
// Clears the slot RAM after reset, then runs one command at a time: probes
// upward from the start slot one slot per cycle; fills a free slot or clears a hit.
// ----------------------------------------------------------------------------
module pfpt_back
	import pfpt_pkg::*;
#(
	parameter int ENTRIES = 64,
	localparam int IDX_W  = $clog2(ENTRIES),
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  cmd_t             pop_cmd,
	input  logic [IDX_W-1:0] pop_start,
	output logic             clearing,
	pfpt_rsp_if.source       rsp
);

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_IDLE  = 4'b0010,
		B_PROBE = 4'b0100,
		B_DONE  = 4'b1000
	} bstate_t;

	bstate_t          state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] addr_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic             chk_vld_q;
	logic             res_matched_q;
	logic             res_status_q;
	logic             out_vld_q;
	logic             out_matched_q;
	logic             out_status_q;

	logic             rd_en;
	slot_t            rd_slot;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	slot_t            wr_slot;
	logic             key_hit;
	logic             last;
	logic             finish;
	logic             fin_matched;
	logic             fin_status;
	logic             out_free;
	logic             known_act;

	pfpt_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (ENTRIES)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot),
		.rd_en   (rd_en),
		.rd_addr (addr_q[IDX_W-1:0]),
		.rd_data (rd_slot)
	);

	assign clearing  = (state_q == B_CLEAR);
	assign pop_ready = (state_q == B_IDLE);
	assign rd_en     = (state_q == B_PROBE) && (addr_q < CNT_W'(ENTRIES));
	assign key_hit   = rd_slot.valid && (rd_slot.key == cmd_q.key);
	assign last      = (chk_idx_q == IDX_W'(ENTRIES - 1));
	assign out_free  = !out_vld_q || rsp.ready;
	assign known_act = (pop_cmd.action == ACT_LOOKUP) || (pop_cmd.action == ACT_INSERT)
		|| (pop_cmd.action == ACT_REMOVE);

	always_comb begin
		finish      = 1'b0;
		fin_matched = 1'b0;
		fin_status  = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = chk_idx_q;
		wr_slot     = '0;
		if (state_q == B_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == B_PROBE && chk_vld_q) begin
			unique case (cmd_q.action)
				ACT_LOOKUP: begin
					finish      = key_hit || last;
					fin_matched = key_hit;
				end
				ACT_INSERT: begin
					finish        = !rd_slot.valid || last;
					fin_status    = rd_slot.valid;
					wr_en         = !rd_slot.valid;
					wr_slot.valid = 1'b1;
					wr_slot.key   = cmd_q.key;
				end
				ACT_REMOVE: begin
					finish = key_hit || last;
					wr_en  = key_hit;
				end
				default: finish = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			chk_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == B_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					chk_vld_q <= 1'b0;
					if (pop_valid) begin
						state_q <= known_act ? B_PROBE : B_DONE;
					end
				end
				B_PROBE: begin
					chk_vld_q <= rd_en;
					if (finish) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			cmd_q         <= pop_cmd;
			addr_q        <= CNT_W'(pop_start);
			res_matched_q <= 1'b0;
			res_status_q  <= 1'b0;
		end else if (state_q == B_PROBE) begin
			if (rd_en) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			chk_idx_q <= addr_q[IDX_W-1:0];
			if (finish) begin
				res_matched_q <= fin_matched;
				res_status_q  <= fin_status;
			end
		end
		if (state_q == B_DONE && out_free) begin
			out_matched_q <= res_matched_q;
			out_status_q  <= res_status_q;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.matched = out_matched_q;
	assign rsp.status  = out_status_q;

endmodule

// ----- design/port_filter_probe_table.sv -----
// ----------------------------------------------------------------------------
// port_filter_probe_table
// Port filter table, linear probing from (port + protocol) mod ENTRIES.
// The modulo is formed in the front part, the command passes the queue, then
//   the back part probes one slot a cycle on the single slot RAM read port;
//   an unused action is answered without probing. A new request can be taken
//   while earlier commands are still being probed.
// Reset: control state clears at once; then a clearing pass writes every slot of
//   the slot RAM, during which no request is accepted.
// ----------------------------------------------------------------------------
module port_filter_probe_table
	import pfpt_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	pfpt_req_if.sink   req,
	pfpt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int QW    = $bits(cmd_t) + IDX_W;

	logic             f_valid;
	logic             f_ready;
	cmd_t             f_cmd;
	logic [IDX_W-1:0] f_start;
	logic             b_valid;
	logic             b_ready;
	cmd_t             b_cmd;
	logic [IDX_W-1:0] b_start;
	logic             clearing;

	pfpt_front #(
		.ENTRIES (ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.hold       (clearing),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.push_start (f_start)
	);

	pfpt_queue #(
		.W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_cmd, f_start}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   ({b_cmd, b_start})
	);

	pfpt_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_cmd   (b_cmd),
		.pop_start (b_start),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule
